// ===== rtl/lpe_pkg.sv =====
`timescale 1ns / 1ps
package lpe_pkg;

  localparam int SENSORS    = 7;
  localparam int PLAIN_TIED = 4;
  localparam int SUM_W      = 14;
  localparam int MAG_W      = 13;
  localparam int ERR_W      = 13;
  localparam int CNT_W      = 3;

  // Divider: radix-16 restoring division, four quotient bits per cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = 4;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int QUO_W         = BITS_PER_STEP * DIV_STEPS;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [SENSORS-1:0] PAIR_BITS  = 7'h30;
  localparam logic [SENSORS-1:0] RIGHT_BIT  = 7'h40;
  localparam logic [SENSORS-1:0] SENSOR_ALL = 7'h7F;

  localparam logic signed [SUM_W-1:0] PAIR_WEIGHT  = 14'sd1500;
  localparam logic signed [SUM_W-1:0] RIGHT_WEIGHT = 14'sd3000;

  localparam logic signed [SUM_W-1:0] POS_WEIGHT [SENSORS] = '{
    -14'sd3000, -14'sd2000, -14'sd1000, 14'sd0, 14'sd1000, 14'sd2000, 14'sd3000
  };

  localparam logic [0:0] REG_BLACK_IS_HIGH  = 1'b0;
  localparam logic [0:0] REG_TIED_PAIR_MODE = 1'b1;

  typedef struct packed {
    logic [SENSORS-1:0] mask;
    logic [CNT_W-1:0]   count;
    logic               neg;
    logic [MAG_W-1:0]   mag;
  } lpe_item_t;

endpackage

// ===== rtl/line_position_estimator.sv =====
`timescale 1ns / 1ps
// Line position estimator for a row of seven digital line sensors.
// Input channel: drive raw_bits and raise push; a word is taken at an edge where
// push is high and full is low. Result channel: while empty is low the oldest
// result sits on line_mask, hit_count, line_seen and position_error, and
// it is taken at an edge where pop is high.
// The front end votes each sample against the last two, corrects polarity and
// forms the weighted sum and count in the accepting cycle, then queues the word
// (two entries). The back end divides the sum by the count in a radix-16
// divider and skips the division when no sensor is active; the queue lets the
// front end accept new words while the divider still works on an earlier one.
// Configuration: cfg_we with cfg_index 0 (black_is_high) or 1 (tied_pair_mode)
// and cfg_data; write it only while the block is idle.
// Reset clears the history ring, the held error, the queue and the result valid
// flag, and sets both configuration bits to one. When the receiver stalls,
// the result stays put, the back end waits with one finished word and the front
// queue fills; full then rises.
module line_position_estimator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [lpe_pkg::SENSORS-1:0]       raw_bits,
  output logic                              empty,
  input  logic                              pop,
  output logic [lpe_pkg::SENSORS-1:0]       line_mask,
  output logic [lpe_pkg::CNT_W-1:0]         hit_count,
  output logic                              line_seen,
  output logic signed [lpe_pkg::ERR_W-1:0]  position_error,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [0:0]                        cfg_data
);
  import lpe_pkg::*;

  logic      black_is_high;
  logic      tied_pair_mode;
  logic      q_push;
  logic      q_take;
  logic      q_full;
  logic      q_empty;
  logic      out_valid;
  lpe_item_t front_item;
  lpe_item_t queue_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_is_high  <= 1'b1;
      tied_pair_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLACK_IS_HIGH:  black_is_high  <= cfg_data[0];
        REG_TIED_PAIR_MODE: tied_pair_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign full  = q_full;
  assign empty = !out_valid;

  lpe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .q_full         (q_full),
    .raw_bits       (raw_bits),
    .black_is_high  (black_is_high),
    .tied_pair_mode (tied_pair_mode),
    .q_push         (q_push),
    .item           (front_item)
  );

  lpe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (front_item),
    .q_full  (q_full),
    .rd      (q_take),
    .rd_data (queue_item),
    .q_empty (q_empty)
  );

  lpe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (queue_item),
    .q_empty        (q_empty),
    .q_take         (q_take),
    .pop            (pop),
    .out_valid      (out_valid),
    .line_mask      (line_mask),
    .hit_count      (hit_count),
    .line_seen      (line_seen),
    .position_error (position_error)
  );

  // The seen flag must agree with the count it was derived from.
  a_seen_matches_count: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (line_seen == (hit_count != '0)))
    else $error("line_seen disagrees with hit_count");

  // The back end must never draw a word from an empty queue.
  a_no_take_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !q_empty)
    else $error("back end took from an empty queue");

  // A stalled result must stay in place until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(position_error) && $stable(line_mask)))
    else $error("waiting result changed before it was taken");

endmodule

// ===== rtl/lpe_front.sv =====
`timescale 1ns / 1ps
module lpe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          q_full,
  input  logic [lpe_pkg::SENSORS-1:0]   raw_bits,
  input  logic                          black_is_high,
  input  logic                          tied_pair_mode,
  output logic                          q_push,
  output lpe_pkg::lpe_item_t            item
);
  import lpe_pkg::*;

  logic [SENSORS-1:0] hist [3];
  logic [SENSORS-1:0] hist_next [3];
  logic [1:0]         write_slot;
  logic [1:0]         slot;
  logic               history_primed;
  logic [SENSORS-1:0] vote;
  logic [SENSORS-1:0] mask;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_abs;
  logic [CNT_W-1:0]   cnt;

  assign q_push = push && !q_full;

  // An out-of-range slot is treated as slot 0.
  assign slot = (write_slot == 2'd3) ? 2'd0 : write_slot;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!history_primed || slot == 2'(i)) begin
        hist_next[i] = raw_bits;
      end else begin
        hist_next[i] = hist[i];
      end
    end
  end

  assign vote = (hist_next[0] & hist_next[1]) | (hist_next[0] & hist_next[2]) |
                (hist_next[1] & hist_next[2]);
  assign mask = black_is_high ? vote : (~vote & SENSOR_ALL);

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < SENSORS; i++) begin
      if (mask[i] && (!tied_pair_mode || i < PLAIN_TIED)) begin
        sum = sum + POS_WEIGHT[i];
        cnt = cnt + 1'b1;
      end
    end
    if (tied_pair_mode) begin
      if ((mask & PAIR_BITS) != '0) begin
        sum = sum + PAIR_WEIGHT;
        cnt = cnt + 1'b1;
      end
      if ((mask & RIGHT_BIT) != '0) begin
        sum = sum + RIGHT_WEIGHT;
        cnt = cnt + 1'b1;
      end
    end
  end

  assign sum_abs = sum[SUM_W-1] ? -sum : sum;

  always_comb begin
    item.mask  = mask;
    item.count = cnt;
    item.neg   = sum[SUM_W-1];
    item.mag   = sum_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_primed <= 1'b0;
      write_slot     <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hist[i] <= '0;
      end
    end else if (q_push) begin
      for (int i = 0; i < 3; i++) begin
        hist[i] <= hist_next[i];
      end
      // The first sample after reset fills the whole ring and leaves the slot alone.
      if (!history_primed) begin
        history_primed <= 1'b1;
      end else begin
        write_slot <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/lpe_queue.sv =====
`timescale 1ns / 1ps
module lpe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  lpe_pkg::lpe_item_t  wr_data,
  output logic                q_full,
  input  logic                rd,
  output lpe_pkg::lpe_item_t  rd_data,
  output logic                q_empty
);
  import lpe_pkg::*;

  lpe_item_t          store [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        store[wr_ptr] <= wr_data;
        wr_ptr        <= (wr_ptr == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lpe_back.sv =====
`timescale 1ns / 1ps
module lpe_back (
  input  logic                              clk,
  input  logic                              rst,
  input  lpe_pkg::lpe_item_t                q_data,
  input  logic                              q_empty,
  output logic                              q_take,
  input  logic                              pop,
  output logic                              out_valid,
  output logic [lpe_pkg::SENSORS-1:0]       line_mask,
  output logic [lpe_pkg::CNT_W-1:0]         hit_count,
  output logic                              line_seen,
  output logic signed [lpe_pkg::ERR_W-1:0]  position_error
);
  import lpe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state;
  logic [STEP_W-1:0]       step;
  lpe_item_t               cur;
  logic [QUO_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [QUO_W-1:0]        quo_step;
  logic [CNT_W-1:0]        rem_step;
  logic [CNT_W:0]          trial;
  logic [QUO_W-1:0]        quo_final;
  logic signed [ERR_W-1:0] quo_s;
  logic signed [ERR_W-1:0] result_err;
  logic signed [ERR_W-1:0] last_error;
  logic                    finishing;
  logic                    retire;

  // Four restoring-division steps; the remainder stays below the count.
  always_comb begin
    rem_step = rem;
    quo_step = quo;
    trial    = '0;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      trial    = {rem_step, quo_step[QUO_W-1]};
      quo_step = {quo_step[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, cur.count}) begin
        trial       = trial - {1'b0, cur.count};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[CNT_W-1:0];
    end
  end

  assign finishing = (state == ST_DIV && step == STEP_W'(DIV_STEPS-1)) || state == ST_DONE;
  assign retire    = finishing && (!out_valid || pop);
  assign q_take    = !q_empty && (state == ST_IDLE || retire);

  assign quo_final  = (state == ST_DONE) ? quo : quo_step;
  assign quo_s      = signed'(quo_final[ERR_W-1:0]);
  assign result_err = (cur.count == '0) ? last_error : (cur.neg ? -quo_s : quo_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      out_valid  <= 1'b0;
      last_error <= '0;
    end else begin
      if (retire) begin
        out_valid      <= 1'b1;
        line_mask      <= cur.mask;
        hit_count      <= cur.count;
        line_seen      <= (cur.count != '0);
        position_error <= result_err;
        if (cur.count != '0) begin
          last_error <= result_err;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (q_take) begin
        cur   <= q_data;
        quo   <= {(QUO_W-MAG_W)'(0), q_data.mag};
        rem   <= '0;
        step  <= '0;
        // With no active position there is nothing to divide.
        state <= (q_data.count == '0) ? ST_DONE : ST_DIV;
      end else if (retire) begin
        state <= ST_IDLE;
      end else if (state == ST_DIV) begin
        quo  <= quo_step;
        rem  <= rem_step;
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS-1)) begin
          state <= ST_DONE;
        end
      end
    end
  end

endmodule

// ===== test/lpe_checker.sv =====
`timescale 1ns / 1ps
module lpe_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              full,
  input  logic [lpe_pkg::SENSORS-1:0]       raw_bits,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [lpe_pkg::SENSORS-1:0]       line_mask,
  input  logic [lpe_pkg::CNT_W-1:0]         hit_count,
  input  logic                              line_seen,
  input  logic signed [lpe_pkg::ERR_W-1:0]  position_error,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [0:0]                        cfg_data,
  output int                                fail_count,
  output int                                pending_words
);
  import lpe_pkg::*;

  typedef struct packed {
    logic [SENSORS-1:0]      mask;
    logic [CNT_W-1:0]        count;
    logic                    seen;
    logic signed [ERR_W-1:0] err;
  } line_word_t;

  localparam int SENSOR_WEIGHT [SENSORS] = '{-3000, -2000, -1000, 0, 1000, 2000, 3000};
  localparam int TIED_WEIGHT = 1500;

  line_word_t              expected_words [$];
  logic [SENSORS-1:0]      history [3];
  logic [1:0]              slot;
  logic                    primed;
  logic signed [ERR_W-1:0] held_error;
  logic                    black_high;
  logic                    tied_mode;
  int                      mismatches = 0;

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Majority filter, polarity and weighted centroid for one accepted word.
  task automatic estimate_position(input logic [SENSORS-1:0] raw, output line_word_t w);
    logic [SENSORS-1:0] a, b, c, voted, m;
    int                 sum, cnt, plain;
    sum = 0;
    cnt = 0;
    if (!primed) begin
      history[0] = raw;
      history[1] = raw;
      history[2] = raw;
      primed = 1'b1;
    end else begin
      history[(slot > 2'd2) ? 0 : slot] = raw;
      slot = (slot >= 2'd2) ? 2'd0 : slot + 2'd1;
    end
    a = history[0];
    b = history[1];
    c = history[2];
    voted = (a & b) | (a & c) | (b & c);
    m = black_high ? voted : ~voted;
    plain = tied_mode ? 4 : SENSORS;
    for (int i = 0; i < plain; i++) begin
      if (m[i]) begin
        sum += SENSOR_WEIGHT[i];
        cnt++;
      end
    end
    if (tied_mode) begin
      // The middle-right pair acts as one sensor half way between its two bits.
      if (m[4] || m[5]) begin
        sum += TIED_WEIGHT;
        cnt++;
      end
      if (m[6]) begin
        sum += SENSOR_WEIGHT[6];
        cnt++;
      end
    end
    if (cnt > 0) held_error = ERR_W'(sum / cnt);
    w.mask  = m;
    w.count = CNT_W'(cnt);
    w.seen  = (cnt > 0);
    w.err   = held_error;
  endtask

  always @(posedge clk) begin
    line_word_t want, fresh;
    if (rst) begin
      history[0] = '0;
      history[1] = '0;
      history[2] = '0;
      slot       = '0;
      primed     = 1'b0;
      held_error = '0;
      black_high = 1'b1;
      tied_mode  = 1'b1;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BLACK_IS_HIGH) black_high = cfg_data[0];
        else if (cfg_index == REG_TIED_PAIR_MODE) tied_mode = cfg_data[0];
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word, line_mask", line_mask, 0);
        end else begin
          want = expected_words.pop_front();
          if (line_mask !== want.mask) report_mismatch("line_mask", line_mask, want.mask);
          if (hit_count !== want.count)
            report_mismatch("hit_count", hit_count, want.count);
          if (line_seen !== want.seen) report_mismatch("line_seen", line_seen, want.seen);
          if (position_error !== want.err)
            report_mismatch("position_error", position_error, want.err);
        end
      end
      if (push && !full) begin
        estimate_position(raw_bits, fresh);
        expected_words.push_back(fresh);
      end
    end
    pending_words <= expected_words.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== test/tb_line_position_estimator.sv =====
`timescale 1ns / 1ps
module tb_line_position_estimator;
  import lpe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 135;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic [SENSORS-1:0]      raw_bits = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [SENSORS-1:0]      line_mask;
  logic [CNT_W-1:0]        hit_count;
  logic                    line_seen;
  logic signed [ERR_W-1:0] position_error;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_index = REG_BLACK_IS_HIGH;
  logic [0:0]              cfg_data = 1'b0;
  int                      fail_count;
  int                      pending_words;
  int                      cycle_count = 0;
  int                      burst_left = 0;

  line_position_estimator u_top (
    .clk, .rst, .push, .full, .raw_bits, .empty, .pop, .line_mask, .hit_count,
    .line_seen, .position_error, .cfg_we, .cfg_index, .cfg_data
  );

  lpe_checker u_check (
    .clk, .rst, .push, .full, .raw_bits, .empty, .pop, .line_mask, .hit_count,
    .line_seen, .position_error, .cfg_we, .cfg_index, .cfg_data, .fail_count,
    .pending_words
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver walks through an eight-bit pop pattern that is redrawn now
  // and then; all-ones gives stall-free stretches, all-zeros backs the block up.
  logic [7:0] pop_pattern = 8'hFF;
  logic [2:0] pattern_bit = '0;
  int         pattern_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 5))
          0: pop_pattern = 8'hFF;
          1: pop_pattern = 8'h00;
          default: pop_pattern = 8'($urandom_range(0, 255));
        endcase
        pattern_left = $urandom_range(16, 80);
      end
      pop <= pop_pattern[pattern_bit];
      pattern_bit++;
      pattern_left--;
    end
  end

  task automatic send_word(input logic [SENSORS-1:0] bits);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    push     <= 1'b1;
    raw_bits <= bits;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic black_high, input logic tied_mode);
    wait_drain();
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLACK_IS_HIGH;
    cfg_data  <= black_high;
    @(posedge clk);
    cfg_index <= REG_TIED_PAIR_MODE;
    cfg_data  <= tied_mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Each sample has to appear twice before the majority filter lets it through.
  localparam logic [SENSORS-1:0] DIRECTED [24] = '{
    7'h7F, 7'h00, 7'h00, 7'h01, 7'h01, 7'h40, 7'h40, 7'h30, 7'h30, 7'h10, 7'h10, 7'h20,
    7'h20, 7'h08, 7'h08, 7'h07, 7'h07, 7'h55, 7'h2A, 7'h2A, 7'h00, 7'h00, 7'h7F, 7'h7F
  };
  localparam logic [1:0] PHASE_CFG [PHASES] = '{
    2'b11, 2'b10, 2'b01, 2'b00, 2'b00, 2'b11, 2'b01, 2'b10
  };

  initial begin
    logic [SENSORS-1:0] run_value;
    int                 run_left;
    run_value = '0;
    run_left  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_word(DIRECTED[i]);

    for (int p = 0; p < PHASES; p++) begin
      write_config(PHASE_CFG[p][1], PHASE_CFG[p][0]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Mostly runs of a held sample so the filter settles on it, with
        // single noisy samples in between.
        if (run_left == 0) begin
          run_value = SENSORS'($urandom_range(0, 127));
          run_left  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 5);
        end
        send_word(run_value);
        run_left--;
        if ($urandom_range(0, 199) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
